FILE: hw/rtl/vertex_happiness_scorer_macros.svh
// Assertion macros for the vertex happiness scorer.
// Used by the RTL modules that assert; expects clk and rst_n in scope.
`ifndef VERTEX_HAPPINESS_SCORER_MACROS_SVH
`define VERTEX_HAPPINESS_SCORER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VHS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/vhs_pkg.sv
// Shared types and constants of the vertex happiness scorer.
// No dependencies; used by every RTL module of the block.
package vhs_pkg;

    localparam int COLOUR_WIDTH = 8;
    localparam int TOTAL_WIDTH  = 32;
    localparam int WEIGHT_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    // Request kinds
    localparam logic REQ_HEADER    = 1'b0;
    localparam logic REQ_NEIGHBOUR = 1'b1;

    // Vertex classes
    localparam logic [1:0] CLASS_HAPPY     = 2'd0;
    localparam logic [1:0] CLASS_POTENTIAL = 2'd1;
    localparam logic [1:0] CLASS_UNHAPPY   = 2'd2;
    localparam logic [1:0] CLASS_NONE      = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HAPPY_WEIGHT     = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POTENTIAL_WEIGHT = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNHAPPY_WEIGHT   = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCORE_UNCOLOURED = 2'd3;

    typedef logic signed [WEIGHT_WIDTH-1:0] weight_t;

    // Classified vertex handed from the classifier to the accumulator
    typedef struct packed {
        logic       ends;
        logic       done;
        logic       subtract;
        logic [1:0] cls;
        weight_t    weight;
    } vertex_res_t;

endpackage

FILE: hw/rtl/vhs_classifier.sv
// Neighbour flag tracking and end-of-vertex classification.
// Depends on vhs_pkg.
module vhs_classifier
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 req_type,
    input  logic [vhs_pkg::COLOUR_WIDTH-1:0]     colour,
    input  logic                                 subtract_weight,
    input  logic                                 end_of_vertex,
    input  logic                                 end_of_graph,
    input  vhs_pkg::weight_t                     happy_weight,
    input  vhs_pkg::weight_t                     potential_weight,
    input  vhs_pkg::weight_t                     unhappy_weight,
    input  logic                                 score_uncoloured,
    output vhs_pkg::vertex_res_t                 res
);

    logic [vhs_pkg::COLOUR_WIDTH-1:0] own_colour_reg, own_colour_next;
    logic [vhs_pkg::COLOUR_WIDTH-1:0] first_colour_reg, first_colour_next;
    logic                             seen_coloured_reg, seen_coloured_next;
    logic                             seen_uncoloured_reg, seen_uncoloured_next;
    logic                             mismatch_reg, mismatch_next;
    logic                             subtract_reg, subtract_next;

    logic [vhs_pkg::COLOUR_WIDTH-1:0] first_eff;
    logic                             seen_col_eff;
    logic                             seen_unc_eff;
    logic                             mismatch_eff;
    logic                             ends;
    logic [1:0]                       cls;

    assign ends = end_of_vertex | end_of_graph;

    always_comb
    begin
        own_colour_next = own_colour_reg;
        subtract_next   = subtract_reg;
        first_eff       = first_colour_reg;
        seen_col_eff    = seen_coloured_reg;
        seen_unc_eff    = seen_uncoloured_reg;
        mismatch_eff    = mismatch_reg;
        if (req_type == vhs_pkg::REQ_HEADER)
        begin
            // a header drops whatever an unfinished vertex left behind
            own_colour_next = colour;
            subtract_next   = subtract_weight;
            first_eff       = '0;
            seen_col_eff    = 1'b0;
            seen_unc_eff    = 1'b0;
            mismatch_eff    = 1'b0;
        end
        else if (colour == '0)
        begin
            seen_unc_eff = 1'b1;
        end
        else
        begin
            if (own_colour_reg != '0)
            begin
                if (colour != own_colour_reg)
                    mismatch_eff = 1'b1;
            end
            else if (seen_coloured_reg && (colour != first_colour_reg))
            begin
                mismatch_eff = 1'b1;
            end
            if (!seen_coloured_reg)
                first_eff = colour;
            seen_col_eff = 1'b1;
        end
    end

    always_comb
    begin
        if (own_colour_next != '0)
            cls = mismatch_eff ? vhs_pkg::CLASS_UNHAPPY :
                  (seen_unc_eff ? vhs_pkg::CLASS_POTENTIAL : vhs_pkg::CLASS_HAPPY);
        else if (score_uncoloured)
            cls = mismatch_eff ? vhs_pkg::CLASS_UNHAPPY :
                  (seen_col_eff ? vhs_pkg::CLASS_POTENTIAL : vhs_pkg::CLASS_NONE);
        else
            cls = vhs_pkg::CLASS_NONE;
    end

    always_comb
    begin
        res.ends     = ends;
        res.done     = end_of_graph;
        res.subtract = subtract_next;
        res.cls      = cls;
        unique case (cls)
            vhs_pkg::CLASS_HAPPY:     res.weight = happy_weight;
            vhs_pkg::CLASS_POTENTIAL: res.weight = potential_weight;
            vhs_pkg::CLASS_UNHAPPY:   res.weight = unhappy_weight;
            default:                  res.weight = '0;
        endcase
    end

    // clear the sticky flags once the vertex is scored
    assign first_colour_next    = ends ? '0 : first_eff;
    assign seen_coloured_next   = ends ? 1'b0 : seen_col_eff;
    assign seen_uncoloured_next = ends ? 1'b0 : seen_unc_eff;
    assign mismatch_next        = ends ? 1'b0 : mismatch_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_colour_reg      <= '0;
            first_colour_reg    <= '0;
            seen_coloured_reg   <= 1'b0;
            seen_uncoloured_reg <= 1'b0;
            mismatch_reg        <= 1'b0;
            subtract_reg        <= 1'b0;
        end
        else if (advance)
        begin
            own_colour_reg      <= own_colour_next;
            first_colour_reg    <= first_colour_next;
            seen_coloured_reg   <= seen_coloured_next;
            seen_uncoloured_reg <= seen_uncoloured_next;
            mismatch_reg        <= mismatch_next;
            subtract_reg        <= subtract_next;
        end
    end

endmodule

FILE: hw/rtl/vhs_accumulator.sv
// Saturating running total and the registered result stage.
// Depends on vhs_pkg and vertex_happiness_scorer_macros.svh.
`include "vertex_happiness_scorer_macros.svh"

module vhs_accumulator
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  vhs_pkg::vertex_res_t        res,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [1:0]                  vertex_class,
    output vhs_pkg::weight_t            vertex_weight,
    output logic [31:0]                 running_total,
    output logic                        total_saturated,
    output logic                        pass_done
);

    localparam int TW = vhs_pkg::TOTAL_WIDTH;

    logic signed [TW-1:0] total_reg, total_next;
    logic                 clip_reg, clip_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           class_reg;
    vhs_pkg::weight_t     weight_reg;
    logic [31:0]          running_reg;
    logic                 sat_reg;
    logic                 done_reg;

    logic signed [TW:0]   total_ext;
    logic signed [TW:0]   weight_ext;
    logic signed [TW:0]   sum;
    logic signed [TW-1:0] total_sat;
    logic                 overflow;
    logic                 clip_after;

    assign total_ext  = (TW+1)'(total_reg);
    assign weight_ext = (TW+1)'(res.weight);
    assign sum        = res.subtract ? (total_ext - weight_ext) : (total_ext + weight_ext);
    assign overflow   = sum[TW] != sum[TW-1];

    always_comb
    begin
        if (!overflow)
            total_sat = sum[TW-1:0];
        else if (sum[TW])
            total_sat = {1'b1, {(TW-1){1'b0}}};
        else
            total_sat = {1'b0, {(TW-1){1'b1}}};
    end

    assign clip_after = clip_reg | overflow;

    // clear the total once the pass closes
    assign total_next     = res.done ? '0 : total_sat;
    assign clip_next      = res.done ? 1'b0 : clip_after;
    assign out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                total_reg <= total_next;
                clip_reg  <= clip_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            class_reg   <= res.cls;
            weight_reg  <= res.weight;
            running_reg <= 32'(total_sat);
            sat_reg     <= clip_after;
            done_reg    <= res.done;
        end
    end

    assign out_valid       = out_valid_reg;
    assign vertex_class    = class_reg;
    assign vertex_weight   = weight_reg;
    assign running_total   = running_reg;
    assign total_saturated = sat_reg;
    assign pass_done       = done_reg;

    `VHS_ASSERT_NEXT(a_pass_clears, load && res.done, total_reg == '0 && !clip_reg, "total not cleared after pass end")
    `VHS_ASSERT_NOW(a_none_zero, out_valid_reg && class_reg == vhs_pkg::CLASS_NONE, weight_reg == '0, "no-contribution result with nonzero weight")
    `VHS_ASSERT_NEXT(a_clip_sticky, load && !res.done && clip_reg, clip_reg, "clip flag dropped inside a pass")
    `VHS_ASSERT_NOW(a_no_overrun, load, !out_valid_reg || out_ready, "result register overwritten before it was taken")

endmodule

FILE: hw/rtl/vertex_happiness_scorer.sv
// A record that ends a vertex is held in the input register; its result is then registered in the output register.
// Throughput: one record per cycle; s_tready drops only while a finished
// result waits in the output register and the record in the input register ends a vertex.
// Reset (rst_n, async, active low) clears flags, total, clip flag and valid bits,
// and loads the weights with happy 1, potential 0, unhappy 0, uncoloured scoring off.
// Depends on vhs_pkg, vhs_classifier and vhs_accumulator.
module vertex_happiness_scorer
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // request stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [15:0]                            s_tdata,   // [7:0] item_colour, [8] subtract_weight
    input  logic                                   s_tlast,   // end_of_vertex
    input  logic [1:0]                             s_tuser,   // [0] req_type, [1] end_of_graph
    // result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [55:0]                            m_tdata,   // [1:0] vertex_class, [17:2] vertex_weight, [49:18] running_total
    output logic                                   m_tlast,   // pass_done
    output logic                                   m_tuser,   // [0] total_saturated
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [vhs_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [15:0]                            cfg_data
);

    vhs_pkg::weight_t happy_reg;
    vhs_pkg::weight_t potential_reg;
    vhs_pkg::weight_t unhappy_reg;
    logic             uncoloured_reg;

    logic       in_valid_reg, in_valid_next;
    logic       req_type_reg;
    logic [7:0] colour_field_reg;
    logic       subtract_reg;
    logic       eov_reg;
    logic       eog_reg;

    logic       s_fire;
    logic       advance;
    logic       cfg_fire;

    vhs_pkg::vertex_res_t res;
    logic [1:0]           vertex_class;
    vhs_pkg::weight_t     vertex_weight;
    logic [31:0]          running_total;
    logic                 total_saturated;
    logic                 pass_done;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            happy_reg      <= vhs_pkg::weight_t'(1);
            potential_reg  <= '0;
            unhappy_reg    <= '0;
            uncoloured_reg <= 1'b0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                vhs_pkg::REG_HAPPY_WEIGHT:     happy_reg      <= cfg_data;
                vhs_pkg::REG_POTENTIAL_WEIGHT: potential_reg  <= cfg_data;
                vhs_pkg::REG_UNHAPPY_WEIGHT:   unhappy_reg    <= cfg_data;
                vhs_pkg::REG_SCORE_UNCOLOURED: uncoloured_reg <= cfg_data[0];
                default:                       uncoloured_reg <= uncoloured_reg;
            endcase
        end
    end

    // advance the held record unless it needs the result slot and the slot is stuck
    assign advance  = in_valid_reg & (~(eov_reg | eog_reg) | ~m_tvalid | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign s_fire   = s_tvalid & s_tready;
    assign in_valid_next = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            req_type_reg     <= s_tuser[0];
            colour_field_reg <= s_tdata[7:0];
            subtract_reg     <= s_tdata[8];
            eov_reg          <= s_tlast;
            eog_reg          <= s_tuser[1];
        end
    end

    vhs_classifier u_classifier
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .req_type         (req_type_reg),
        .colour           (vhs_pkg::COLOUR_WIDTH'(colour_field_reg)),
        .subtract_weight  (subtract_reg),
        .end_of_vertex    (eov_reg),
        .end_of_graph     (eog_reg),
        .happy_weight     (happy_reg),
        .potential_weight (potential_reg),
        .unhappy_weight   (unhappy_reg),
        .score_uncoloured (uncoloured_reg),
        .res              (res)
    );

    vhs_accumulator u_accumulator
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (advance & res.ends),
        .res             (res),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .vertex_class    (vertex_class),
        .vertex_weight   (vertex_weight),
        .running_total   (running_total),
        .total_saturated (total_saturated),
        .pass_done       (pass_done)
    );

    assign m_tdata = {6'd0, running_total, vertex_weight, vertex_class};
    assign m_tlast = pass_done;
    assign m_tuser = total_saturated;

endmodule
